// ===== sv/xms_pkg.sv =====
// Package: request and status codes, controller command/status structs.
package xms_pkg;

  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned StatusW  = 3;

  typedef enum logic [2:0] {
    REQ_ALLOC  = 3'd0,
    REQ_FREE   = 3'd1,
    REQ_RESIZE = 3'd2,
    REQ_LOCK   = 3'd3,
    REQ_UNLOCK = 3'd4,
    REQ_INFO   = 3'd5,
    REQ_QUERY  = 3'd6,
    REQ_NONE   = 3'd7
  } req_type_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_MEM   = 3'd1;
  localparam logic [2:0] ST_BAD_HDL  = 3'd2;
  localparam logic [2:0] ST_LOCKED   = 3'd3;
  localparam logic [2:0] ST_NOT_LOCK = 3'd4;

  localparam logic [15:0] Sat16 = 16'hFFFF;
  localparam logic [7:0]  LockMax = 8'hFF;

  typedef struct packed {
    logic load;    // capture request, clear scan state
    logic div;     // one step of the page count divider
    logic scan;    // one page of the operation scan
    logic commit;  // one page of the write pass
    logic stat;    // one page of the free space scan
    logic mul;     // one step of the kilobyte multiplier
    logic finish;  // form result word
  } xms_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic commit_done;
    logic stat_done;
    logic mul_done;
    logic need_commit;
  } xms_sts_t;

endpackage

// ===== sv/xms_page_block_allocator_top.sv =====
// Top level: page block allocator with a stream request and result channel.
//
//   channel  dir  tdata fields (lsb first)
//   s_axis   in   req_type[2:0] handle[18:3] size_kb[34:19]
//   m_axis   out  status, new_handle, block_address, lock_count, free_pages,
//                 block_kb, largest_free_kb, total_free_kb
//   cfg      in   0 page_kb, 1 base_address, 2 reserved_kb
//
// A request passes, after acceptance, through a divide for the page count, a
// table scan from the handle (or from page 0 for alloc), a resolve step plus a
// write pass over the block, a free space scan and a shift-add multiply by
// page_kb, before the result word. Reset empties the table at once.
// The result word holds until taken; the next request waits for that.
module xms_page_block_allocator_top import xms_pkg::*; #(
  parameter int unsigned Pages = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // req_type, handle, size_kb
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // status, new_handle, block_address,
                                      // lock_count, free_pages, block_kb,
                                      // largest_free_kb, total_free_kb
);

  xms_cmd_t cmd;
  xms_sts_t sts;
  logic [2:0]  status;
  logic [4:0]  new_handle, free_pages;
  logic [31:0] block_address;
  logic [7:0]  lock_count;
  logic [15:0] block_kb, largest_free_kb, total_free_kb;

  xms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  xms_dp #(.Pages(Pages)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i(s_axis_tdata[2:0]), .handle_i(s_axis_tdata[18:3]),
    .size_kb_i(s_axis_tdata[34:19]),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(status), .new_handle_o(new_handle), .block_address_o(block_address),
    .lock_count_o(lock_count), .free_pages_o(free_pages), .block_kb_o(block_kb),
    .largest_free_kb_o(largest_free_kb), .total_free_kb_o(total_free_kb)
  );

  assign m_axis_tdata = {3'd0, total_free_kb, largest_free_kb, block_kb, free_pages,
                         lock_count, block_address, new_handle, status};

endmodule

// ===== sv/xms_ctrl.sv =====
// Controller: sequences load, divide, scan, commit, free scan, multiply, finish, output.
module xms_ctrl import xms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  xms_sts_t sts_i,
  output xms_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_COMMIT = 8'b0000_1000,
    S_STAT   = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_done) state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = sts_i.need_commit ? S_COMMIT : S_STAT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (sts_i.commit_done) state_d = S_STAT;
      end
      S_STAT: begin
        cmd_o.stat = 1'b1;
        if (sts_i.stat_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.mul_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/xms_dp.sv =====
// Datapath: page table, divider, scans, multipliers and result registers.
module xms_dp import xms_pkg::*; #(
  parameter int unsigned Pages = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] handle_i,
  input  logic [15:0] size_kb_i,
  input  xms_cmd_t    cmd_i,
  output xms_sts_t    sts_o,
  output logic [2:0]  status_o,
  output logic [4:0]  new_handle_o,
  output logic [31:0] block_address_o,
  output logic [7:0]  lock_count_o,
  output logic [4:0]  free_pages_o,
  output logic [15:0] block_kb_o,
  output logic [15:0] largest_free_kb_o,
  output logic [15:0] total_free_kb_o
);

  localparam int unsigned IdxW = (Pages > 1) ? $clog2(Pages) : 1;
  localparam int unsigned CntW = $clog2(Pages + 1);

  logic [15:0] page_kb_q, reserved_kb_q;
  logic [23:0] base_q;
  logic [4:0]  owner_q [Pages];
  logic [7:0]  locks_q [Pages];

  logic [2:0]  req_q;
  logic [15:0] hdl_q;
  logic [15:0] pk;
  logic        hvalid;
  logic [IdxW-1:0] h0;

  // divider
  logic [16:0] rem_q;
  logic [15:0] quo_q, dvd_q;
  logic [4:0]  dstep_q;
  logic [16:0] need_q;

  // scan
  logic [CntW-1:0] ptr_q;
  logic [CntW-1:0] len_q, run_q, start_q;
  logic            in_blk_q, grow_q, found_q;
  logic [CntW-1:0] cur_q;

  // commit / result
  logic [2:0]  st_q;
  logic [4:0]  newh_q;
  logic [7:0]  lcnt_q;
  logic        wr_q;
  logic        res_q;
  logic [CntW-1:0] wbase_q, wnum_q, wneed_q, cptr_q;
  logic [1:0]  wmode_q;
  localparam logic [1:0] W_ALLOC = 2'd0, W_FREE = 2'd1, W_RESIZE = 2'd2, W_LOCK = 2'd3;

  // stats
  logic [CntW-1:0] fp_q, best_q, srun_q;
  // multiply
  logic [4:0]  mstep_q;
  logic [31:0] mbest_q, mfree_q, mlen_q, maddr_q;

  logic [15:0] res_bkb_q, res_lf_q, res_tf_q;
  logic [31:0] res_addr_q;

  assign pk = (page_kb_q == 16'd0) ? 16'd1 : page_kb_q;
  assign h0 = IdxW'(hdl_q - 16'd1);
  assign hvalid = (hdl_q >= 16'd1) && (hdl_q <= 16'(Pages)) &&
                  (owner_q[h0] == 5'(hdl_q));

  function automatic logic [15:0] less_res(input logic [31:0] kb, input logic [15:0] r);
    logic [31:0] v;
    v = (kb > 32'(r)) ? kb - 32'(r) : kb;
    return (v > 32'(Sat16)) ? Sat16 : v[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_kb_q <= 16'd512;
      base_q <= 24'd1114112;
      reserved_kb_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        2'd0: page_kb_q <= cfg_data_i[15:0];
        2'd1: base_q <= cfg_data_i;
        2'd2: reserved_kb_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic ptr_end;
  assign ptr_end = (ptr_q == CntW'(Pages - 1));
  logic [IdxW-1:0] pi;
  assign pi = IdxW'(ptr_q);
  logic pfree;
  assign pfree = (owner_q[pi] == 5'd0);

  always_comb begin
    sts_o = '0;
    sts_o.div_done = (dstep_q == 5'd16);
    sts_o.scan_done = ptr_end || (req_q != REQ_ALLOC && req_q != REQ_RESIZE &&
                      req_q != REQ_FREE && req_q != REQ_LOCK && req_q != REQ_UNLOCK
                      && req_q != REQ_INFO);
    sts_o.commit_done = res_q && (!wr_q || (cptr_q == wnum_q));
    sts_o.stat_done = ptr_end;
    sts_o.mul_done = (mstep_q == 5'd16);
    sts_o.need_commit = 1'b1;
  end

  integer k;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < Pages; k++) begin
        owner_q[k] <= '0;
        locks_q[k] <= '0;
      end
    end else if (cmd_i.commit && res_q && wr_q && cptr_q != wnum_q) begin
      case (wmode_q)
        W_ALLOC: begin
          owner_q[IdxW'(wbase_q + cptr_q)] <= 5'(wbase_q + 1'b1);
          locks_q[IdxW'(wbase_q + cptr_q)] <= '0;
        end
        W_FREE: begin
          owner_q[IdxW'(wbase_q + cptr_q)] <= '0;
          locks_q[IdxW'(wbase_q + cptr_q)] <= '0;
        end
        W_RESIZE: begin
          if (cptr_q < wneed_q) owner_q[IdxW'(wbase_q + cptr_q)] <= 5'(wbase_q + 1'b1);
          else if (cptr_q < len_q) owner_q[IdxW'(wbase_q + cptr_q)] <= '0;
          locks_q[IdxW'(wbase_q + cptr_q)] <= '0;
        end
        W_LOCK: locks_q[IdxW'(wbase_q + cptr_q)] <= lcnt_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      hdl_q <= handle_i;
      dvd_q <= size_kb_i;
      rem_q <= '0;
      quo_q <= '0;
      dstep_q <= '0;
      ptr_q <= '0;
      len_q <= '0;
      run_q <= '0;
      cur_q <= '0;
      in_blk_q <= 1'b1;
      grow_q <= 1'b1;
      found_q <= 1'b0;
      start_q <= '0;
      cptr_q <= '0;
      wr_q <= 1'b0;
      res_q <= 1'b0;
      st_q <= ST_OK;
      newh_q <= '0;
      lcnt_q <= '0;
    end
    if (cmd_i.div) begin
      if (dstep_q != 5'd16) begin
        if ({rem_q[15:0], dvd_q[15]} >= {1'b0, pk}) begin
          rem_q <= {rem_q[15:0], dvd_q[15]} - {1'b0, pk};
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= {rem_q[15:0], dvd_q[15]};
          quo_q <= {quo_q[14:0], 1'b0};
        end
        dvd_q <= {dvd_q[14:0], 1'b0};
        dstep_q <= dstep_q + 5'd1;
      end else begin
        need_q <= (quo_q == 16'd0 && rem_q == 17'd0) ? 17'd1 :
                  17'(quo_q) + ((rem_q != 17'd0) ? 17'd1 : 17'd0);
        if (req_q != REQ_ALLOC) ptr_q <= CntW'(h0);
        if (req_q != REQ_ALLOC && !hvalid) ptr_q <= CntW'(Pages - 1);
      end
    end
    if (cmd_i.scan) begin
      if (!ptr_end) ptr_q <= ptr_q + 1'b1;
      case (req_q)
        REQ_ALLOC: begin
          if (!found_q) begin
            if (pfree) begin
              if (cur_q == '0) start_q <= ptr_q;
              cur_q <= cur_q + 1'b1;
              if (17'(cur_q) + 17'd1 >= need_q) begin
                found_q <= 1'b1;
                wnum_q <= CntW'(need_q);
                wbase_q <= (cur_q == '0) ? ptr_q : start_q;
              end
            end else begin
              cur_q <= '0;
            end
          end
        end
        default: begin
          if (hvalid) begin
            if (in_blk_q && owner_q[pi] == 5'(hdl_q)) begin
              len_q <= len_q + 1'b1;
              run_q <= run_q + 1'b1;
            end else begin
              in_blk_q <= 1'b0;
              if (grow_q && pfree) run_q <= run_q + 1'b1;
              else grow_q <= 1'b0;
            end
          end
        end
      endcase
      if (sts_o.scan_done) begin
        wbase_q <= (req_q == REQ_ALLOC) ? ((found_q || !(pfree &&
                    17'(cur_q) + 17'd1 >= need_q)) ? wbase_q :
                    ((cur_q == '0) ? ptr_q : start_q)) : CntW'(h0);
        case (req_q)
          REQ_ALLOC: begin
            if (found_q || (pfree && 17'(cur_q) + 17'd1 >= need_q)) begin
              wr_q <= 1'b1;
              wmode_q <= W_ALLOC;
              wnum_q <= CntW'(need_q);
              newh_q <= 5'(((found_q) ? wbase_q : ((cur_q == '0) ? ptr_q : start_q)) + 1'b1);
            end else st_q <= ST_NO_MEM;
          end
          REQ_FREE, REQ_RESIZE, REQ_LOCK, REQ_UNLOCK, REQ_INFO: begin
            if (!hvalid) st_q <= ST_BAD_HDL;
          end
          default: ;
        endcase
      end
    end
    // resolve handle requests on the first commit cycle using final len/run
    if (cmd_i.commit && !res_q) begin
      res_q <= 1'b1;
      if (req_q != REQ_ALLOC && hvalid && st_q == ST_OK) begin
        case (req_q)
          REQ_FREE: begin
            if (locks_q[h0] != 8'd0) st_q <= ST_LOCKED;
            else begin wr_q <= 1'b1; wmode_q <= W_FREE; wnum_q <= len_q; end
          end
          REQ_RESIZE: begin
            if (locks_q[h0] != 8'd0) st_q <= ST_LOCKED;
            else if (need_q > 17'(run_q)) st_q <= ST_NO_MEM;
            else begin
              wr_q <= 1'b1; wmode_q <= W_RESIZE; wnum_q <= run_q;
              wneed_q <= CntW'(need_q);
            end
          end
          REQ_LOCK: begin
            lcnt_q <= (locks_q[h0] == LockMax) ? LockMax : locks_q[h0] + 8'd1;
            wr_q <= 1'b1; wmode_q <= W_LOCK; wnum_q <= len_q;
          end
          REQ_UNLOCK: begin
            if (locks_q[h0] == 8'd0) st_q <= ST_NOT_LOCK;
            else begin
              lcnt_q <= locks_q[h0] - 8'd1;
              wr_q <= 1'b1; wmode_q <= W_LOCK; wnum_q <= len_q;
            end
          end
          REQ_INFO: lcnt_q <= locks_q[h0];
          default: ;
        endcase
      end
    end else if (cmd_i.commit && wr_q && cptr_q != wnum_q) begin
      cptr_q <= cptr_q + 1'b1;
    end
    if (cmd_i.commit && sts_o.commit_done) begin
      ptr_q <= '0;
      fp_q <= '0;
      best_q <= '0;
      srun_q <= '0;
    end
    if (cmd_i.stat) begin
      if (!ptr_end) ptr_q <= ptr_q + 1'b1;
      if (pfree) begin
        fp_q <= fp_q + 1'b1;
        srun_q <= srun_q + 1'b1;
        if (srun_q + 1'b1 > best_q) best_q <= srun_q + 1'b1;
      end else srun_q <= '0;
      if (ptr_end) begin
        mstep_q <= '0;
        mbest_q <= '0;
        mfree_q <= '0;
        mlen_q <= '0;
        maddr_q <= '0;
      end
    end
    if (cmd_i.mul && mstep_q != 5'd16) begin
      mstep_q <= mstep_q + 5'd1;
      if (pk[4'(15 - mstep_q)]) begin
        mbest_q <= (mbest_q << 1) + 32'(best_q);
        mfree_q <= (mfree_q << 1) + 32'(fp_q);
        mlen_q <= (mlen_q << 1) + 32'(len_q);
        maddr_q <= (maddr_q << 1) + 32'(h0);
      end else begin
        mbest_q <= mbest_q << 1;
        mfree_q <= mfree_q << 1;
        mlen_q <= mlen_q << 1;
        maddr_q <= maddr_q << 1;
      end
    end
    if (cmd_i.finish) begin
      res_lf_q <= less_res(mbest_q, reserved_kb_q);
      res_tf_q <= less_res(mfree_q, reserved_kb_q);
      res_bkb_q <= (req_q == REQ_INFO && st_q == ST_OK) ?
                   ((mlen_q > 32'(Sat16)) ? Sat16 : mlen_q[15:0]) : 16'd0;
      res_addr_q <= (req_q == REQ_LOCK && st_q == ST_OK) ?
                    32'(base_q) + {maddr_q[21:0], 10'd0} : 32'd0;
    end
  end

  assign status_o = st_q;
  assign new_handle_o = newh_q;
  assign block_address_o = res_addr_q;
  assign lock_count_o = (st_q == ST_OK) ? lcnt_q : 8'd0;
  assign free_pages_o = 5'(fp_q);
  assign block_kb_o = res_bkb_q;
  assign largest_free_kb_o = res_lf_q;
  assign total_free_kb_o = res_tf_q;

endmodule
